### src/utf8d_pkg.sv
// Shared types, constants and helper functions for the UTF-8 stream decoder.
// Used by utf8d_decode and utf8_stream_decoder_top; depends on nothing else.
package utf8d_pkg;

   localparam int MAX_SEQ_BYTES = 6;

   localparam logic [30:0] SUBST_CHAR = 31'd63;

   // Sequence state carried from one byte to the next.
   typedef struct packed {
      logic [2:0]  needed;
      logic [2:0]  taken;
      logic [2:0]  seq_len;
      logic [30:0] acc;
   } seq_state_type;

   // Result items caused by one byte: a run of substitutions, then an optional tail item.
   typedef struct packed {
      logic [2:0]  q_cnt;
      logic        tail_vld;
      logic [30:0] tail_cp;
      logic        tail_rep;
      logic        tail_end;
   } job_type;

   // Smallest value that a sequence of the given length may encode.
   function automatic logic [30:0] min_value(input logic [2:0] len);
      logic [30:0] val;
      case (len)
         3'd2:    val = 31'h0000080;
         3'd3:    val = 31'h0000800;
         3'd4:    val = 31'h0010000;
         3'd5:    val = 31'h0200000;
         3'd6:    val = 31'h4000000;
         default: val = 31'h0000000;
      endcase
      return val;
   endfunction

endpackage

### src/utf8d_decode.sv
// Combinational decode of one byte against the pending sequence state.
// Produces the next state and the result items for the byte; uses utf8d_pkg.
module utf8d_decode (
   input  logic [7:0]              byte_in,
   input  utf8d_pkg::seq_state_type st,
   output utf8d_pkg::seq_state_type st_next,
   output utf8d_pkg::job_type      job
);

   logic [3:0]  lead_len;
   logic        is_cont;
   logic        idle_eval;
   logic [30:0] acc_ext;
   logic [7:0]  lead_mask;

   always_comb begin
      if (byte_in inside {[8'h00:8'h7F]}) begin
         lead_len = 4'd0;
      end else if (byte_in inside {[8'h80:8'hBF]}) begin
         lead_len = 4'd1;
      end else if (byte_in inside {[8'hC0:8'hDF]}) begin
         lead_len = 4'd2;
      end else if (byte_in inside {[8'hE0:8'hEF]}) begin
         lead_len = 4'd3;
      end else if (byte_in inside {[8'hF0:8'hF7]}) begin
         lead_len = 4'd4;
      end else if (byte_in inside {[8'hF8:8'hFB]}) begin
         lead_len = 4'd5;
      end else if (byte_in inside {[8'hFC:8'hFD]}) begin
         lead_len = 4'd6;
      end else if (byte_in == 8'hFE) begin
         lead_len = 4'd7;
      end else begin
         lead_len = 4'd8;
      end
   end

   assign is_cont   = (byte_in[7:6] == 2'b10);
   assign acc_ext   = {st.acc[24:0], byte_in[5:0]};
   assign lead_mask = 8'h7F >> lead_len;

   always_comb begin
      st_next   = st;
      job       = '0;
      idle_eval = 1'b0;
      if (st.needed != 3'd0) begin
         if (is_cont) begin
            st_next.acc    = acc_ext;
            st_next.taken  = st.taken + 3'd1;
            st_next.needed = st.needed - 3'd1;
            if (st.needed == 3'd1) begin
               st_next = '0;
               if (acc_ext < utf8d_pkg::min_value(st.seq_len)) begin
                  job.q_cnt = st.seq_len;
               end else begin
                  job.tail_vld = 1'b1;
                  job.tail_cp  = acc_ext;
               end
            end
         end else begin
            job.q_cnt = (st.taken >= 3'd4) ? 3'd5 : st.taken + 3'd1;
            st_next   = '0;
            idle_eval = 1'b1;
         end
      end else begin
         idle_eval = 1'b1;
      end

      if (idle_eval) begin
         if (byte_in == 8'h00) begin
            job.tail_vld = 1'b1;
            job.tail_end = 1'b1;
         end else if (lead_len == 4'd0) begin
            job.tail_vld = 1'b1;
            job.tail_cp  = {23'd0, byte_in};
         end else if (lead_len < 4'd2 ||
                      lead_len > 4'(utf8d_pkg::MAX_SEQ_BYTES)) begin
            job.tail_vld = 1'b1;
            job.tail_cp  = utf8d_pkg::SUBST_CHAR;
            job.tail_rep = 1'b1;
         end else begin
            st_next.seq_len = lead_len[2:0];
            st_next.needed  = lead_len[2:0] - 3'd1;
            st_next.taken   = 3'd0;
            st_next.acc     = {23'd0, byte_in & lead_mask};
         end
      end
   end

endmodule

### src/utf8_stream_decoder_top.sv
// Top level of the UTF-8 stream decoder: input register, decode, result queue.
// Instantiates utf8d_decode; uses utf8d_pkg.
// A byte accepted into the input register is decoded into the result register
// once that register is free; its results are then offered from there.
// Input takes one byte per cycle while each byte gives at most one result and the
// receiver is ready; more results hold the result register until the last is taken.
// Reset (synchronous, active high) empties both registers and clears the sequence.
module utf8_stream_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_code_point,
   output logic        rsp_replaced,
   output logic        rsp_end_mark,
   output logic        rsp_last
);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff, in_byte_in;
   utf8d_pkg::seq_state_type  st_ff, st_in, st_dec;
   utf8d_pkg::job_type        job_ff, job_in, job_dec;
   logic                      job_empty;
   logic                      job_one;
   logic                      in_move;
   logic                      rsp_xfer;

   utf8d_decode u_decode (
      .byte_in (in_byte_ff),
      .st      (st_ff),
      .st_next (st_dec),
      .job     (job_dec)
   );

   assign job_empty = (job_ff.q_cnt == 3'd0) && !job_ff.tail_vld;
   assign job_one   = ((job_ff.q_cnt == 3'd1) && !job_ff.tail_vld) ||
                      ((job_ff.q_cnt == 3'd0) && job_ff.tail_vld);
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign in_move   = in_valid_ff && (job_empty || (rsp_ready && job_one));
   assign req_ready = !in_valid_ff || in_move;

   assign rsp_valid      = !job_empty;
   assign rsp_code_point = (job_ff.q_cnt != 3'd0) ? utf8d_pkg::SUBST_CHAR : job_ff.tail_cp;
   assign rsp_replaced   = (job_ff.q_cnt != 3'd0) ? 1'b1 : job_ff.tail_rep;
   assign rsp_end_mark   = (job_ff.q_cnt != 3'd0) ? 1'b0 : job_ff.tail_end;
   assign rsp_last       = job_one;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      st_in       = st_ff;
      job_in      = job_ff;
      if (in_move) begin
         in_valid_in = 1'b0;
         st_in       = st_dec;
         job_in      = job_dec;
      end else if (rsp_xfer) begin
         if (job_ff.q_cnt != 3'd0) begin
            job_in.q_cnt = job_ff.q_cnt - 3'd1;
         end else begin
            job_in.tail_vld = 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         st_ff           <= '0;
         job_ff.q_cnt    <= 3'd0;
         job_ff.tail_vld <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         st_ff           <= st_in;
         job_ff.q_cnt    <= job_in.q_cnt;
         job_ff.tail_vld <= job_in.tail_vld;
      end
      in_byte_ff      <= in_byte_in;
      job_ff.tail_cp  <= job_in.tail_cp;
      job_ff.tail_rep <= job_in.tail_rep;
      job_ff.tail_end <= job_in.tail_end;
   end

endmodule
